// ----- design/ofdmbi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ofdmbi_pkg;

  localparam int COLUMNS         = 16;
  localparam int MAX_SUBCARRIERS = 256;

  localparam int IDX_W  = 16;
  localparam int SYM_W  = 12;
  localparam int POS_W  = 11;
  localparam int DEST_W = 17;
  localparam int SC_W   = 8;
  localparam int SUBC_W = 9;
  localparam int MULT_W = 5;
  localparam int DIV_W  = 7;
  localparam int LOW_W  = 4;

  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = SYM_W / DIV_STEPS;
  localparam int PIPE_LAT   = DIV_STAGES + 3;

  localparam logic [SUBC_W-1:0] SUBC_RESET = 9'd80;
  localparam logic [MULT_W-1:0] MULT_RESET = 5'd5;
  localparam logic [SUBC_W-1:0] SUBC_MIN   = 9'(COLUMNS);
  localparam logic [SUBC_W-1:0] SUBC_MAX   = 9'(MAX_SUBCARRIERS);

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_NUM_SUBC = 1'b0;

  localparam logic [1:0] MOD_BPSK  = 2'd0;
  localparam logic [1:0] MOD_QPSK  = 2'd1;
  localparam logic [1:0] MOD_16QAM = 2'd2;
  localparam logic [1:0] MOD_64QAM = 2'd3;

  typedef struct packed {
    logic [MULT_W-1:0] mult;
  } cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [SYM_W-1:0] work;
    logic [LOW_W-1:0] low;
    logic [IDX_W-1:0] idx;
    logic [DIV_W-1:0] div;
    logic [1:0]       modulation;
    logic             data_bit;
  } pipe_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_number;
    logic [POS_W-1:0]  permuted_position;
    logic [DEST_W-1:0] dest_index;
    logic [SC_W-1:0]   subcarrier;
    logic              bit_out;
  } res_t;

endpackage

`default_nettype wire

// ----- design/ofdmbi_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofdmbi_cfg
  import ofdmbi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [SUBC_W-1:0] subc_r, subc_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic              wr_en;
  logic              sel_subc;

  assign pready   = 1'b1;
  assign sel_subc = (paddr[CFG_ADDR_W-1] == REG_NUM_SUBC);
  assign wr_en    = psel && penable && pwrite && pready && sel_subc;

  always_comb begin
    subc_nxt = subc_r;
    mult_nxt = mult_r;
    if (wr_en) begin
      subc_nxt = pwdata[SUBC_W-1:0];
      if (pwdata[SUBC_W-1:0] < SUBC_MIN) begin
        mult_nxt = MULT_W'(1);
      end else if (pwdata[SUBC_W-1:0] > SUBC_MAX) begin
        mult_nxt = MULT_W'(MAX_SUBCARRIERS / COLUMNS);
      end else begin
        mult_nxt = pwdata[SUBC_W-1:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subc_r <= SUBC_RESET;
      mult_r <= MULT_RESET;
    end else begin
      subc_r <= subc_nxt;
      mult_r <= mult_nxt;
    end
  end

  assign prdata   = sel_subc ? {{(32 - SUBC_W){1'b0}}, subc_r} : 32'd0;
  assign cfg.mult = mult_r;

endmodule

`default_nettype wire

// ----- design/ofdmbi_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofdmbi_div_stage
  import ofdmbi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_vld,
  input  wire pipe_t in_pipe,
  output logic       out_vld,
  output pipe_t      out_pipe
);

  logic  vld_r;
  pipe_t pipe_r, pipe_nxt;

  always_comb begin
    logic [DIV_W:0] trial;
    logic           ge;
    pipe_nxt = in_pipe;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {pipe_nxt.rem, pipe_nxt.work[SYM_W-1]};
      ge    = (trial >= {1'b0, pipe_nxt.div});
      pipe_nxt.work = {pipe_nxt.work[SYM_W-2:0], ge};
      pipe_nxt.rem  = ge ? DIV_W'(trial - {1'b0, pipe_nxt.div}) : trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pipe_r <= pipe_nxt;
  end

  assign out_vld  = vld_r;
  assign out_pipe = pipe_r;

endmodule

`default_nettype wire

// ----- design/ofdmbi_perm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofdmbi_perm
  import ofdmbi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_vld,
  input  wire pipe_t in_pipe,
  output logic       out_vld,
  output res_t       out_res
);

  logic              a_vld_r;
  logic [POS_W-1:0]  a_pos_r, a_pos_nxt;
  logic [SYM_W-1:0]  a_sym_r;
  logic [DIV_W-1:0]  a_rem_r;
  logic [LOW_W-1:0]  a_low_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [1:0]        a_mod_r;
  logic              a_bit_r;

  logic              b_vld_r;
  res_t              b_res_r, b_res_nxt;

  logic [14:0]       rem_prod;
  logic [7:0]        low_prod;
  logic [DIV_W-1:0]  rem_m3;
  logic [LOW_W-1:0]  low_m3;
  logic [2:0]        diff3;
  logic [1:0]        adj3;
  logic [POS_W-1:0]  dl;
  logic [POS_W-1:0]  base;
  logic [1:0]        adj;

  // interleave step two within groups of s bits
  assign rem_prod = 15'(in_pipe.rem) * 15'd171;
  assign low_prod = 8'(in_pipe.low) * 8'd11;
  assign rem_m3   = DIV_W'(in_pipe.rem - 7'(3 * rem_prod[14:9]));
  assign low_m3   = LOW_W'(in_pipe.low - 4'(3 * low_prod[7:5]));
  assign diff3    = 3'(rem_m3[1:0]) + 3'd3 - 3'(low_m3[1:0]);
  assign adj3     = (diff3 >= 3'd3) ? 2'(diff3 - 3'd3) : diff3[1:0];
  assign dl       = POS_W'(in_pipe.div) * POS_W'(in_pipe.low);

  always_comb begin
    unique case (in_pipe.modulation)
      MOD_16QAM: begin
        base = POS_W'({in_pipe.rem[DIV_W-1:1], 1'b0});
        adj  = {1'b0, in_pipe.rem[0] ^ in_pipe.low[0]};
      end
      MOD_64QAM: begin
        base = POS_W'(in_pipe.rem - rem_m3);
        adj  = adj3;
      end
      default: begin
        base = POS_W'(in_pipe.rem);
        adj  = 2'd0;
      end
    endcase
    a_pos_nxt = dl + base + POS_W'(adj);
  end

  logic [9:0]  half_pos;
  logic [19:0] third_prod;

  assign half_pos   = a_pos_r[POS_W-1:1];
  assign third_prod = 20'(half_pos) * 20'd683;

  always_comb begin
    b_res_nxt.symbol_number     = a_sym_r;
    b_res_nxt.permuted_position = a_pos_r;
    b_res_nxt.bit_out           = a_bit_r;
    b_res_nxt.dest_index        = DEST_W'({1'b0, a_idx_r}) - DEST_W'({a_rem_r, a_low_r})
                                  + DEST_W'(a_pos_r);
    unique case (a_mod_r)
      MOD_BPSK:  b_res_nxt.subcarrier = a_pos_r[SC_W-1:0];
      MOD_QPSK:  b_res_nxt.subcarrier = a_pos_r[SC_W:1];
      MOD_16QAM: b_res_nxt.subcarrier = a_pos_r[SC_W+1:2];
      MOD_64QAM: b_res_nxt.subcarrier = third_prod[18:11];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_pos_r <= a_pos_nxt;
    a_sym_r <= in_pipe.work;
    a_rem_r <= in_pipe.rem;
    a_low_r <= in_pipe.low;
    a_idx_r <= in_pipe.idx;
    a_mod_r <= in_pipe.modulation;
    a_bit_r <= in_pipe.data_bit;
    b_res_r <= b_res_nxt;
  end

  assign out_vld = b_vld_r;
  assign out_res = b_res_r;

endmodule

`default_nettype wire

// ----- design/ofdm_bit_interleave_address.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake              Payload
// input     start / busy           in_bit_index, in_modulation, in_data_bit
// result    out_valid strobe       out_symbol_number, out_permuted_position,
//                                  out_dest_index, out_subcarrier, out_bit_out
// config    APB psel/penable       paddr, pwdata, prdata (num_subcarriers at 0x0)
//
// One request per cycle while busy is low. Each request passes through the symbol
// divider: four stages of three restoring steps, plus an input stage and two
// permutation stages, each of them registered.
// busy is high during reset and for the cycle after it, low otherwise.
// The receiver cannot stall, so the pipeline never holds.

module ofdm_bit_interleave_address
  import ofdmbi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [IDX_W-1:0]      in_bit_index,
  input  wire logic [1:0]            in_modulation,
  input  wire logic                  in_data_bit,
  output logic                       out_valid,
  output logic [SYM_W-1:0]           out_symbol_number,
  output logic [POS_W-1:0]           out_permuted_position,
  output logic [DEST_W-1:0]          out_dest_index,
  output logic [SC_W-1:0]            out_subcarrier,
  output logic                       out_bit_out,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  cfg_t  cfg;
  logic  busy_r;
  logic  s0_vld_r;
  pipe_t s0_pipe_r, s0_pipe_nxt;
  logic [DIV_W-1:0] div_nxt;
  logic  accept;
  res_t  res;

  logic  div_vld  [DIV_STAGES+1];
  pipe_t div_pipe [DIV_STAGES+1];

  ofdmbi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // divisor is coded bits per symbol over sixteen
  always_comb begin
    unique case (in_modulation)
      MOD_BPSK:  div_nxt = DIV_W'(cfg.mult);
      MOD_QPSK:  div_nxt = DIV_W'({cfg.mult, 1'b0});
      MOD_16QAM: div_nxt = DIV_W'({cfg.mult, 2'b0});
      MOD_64QAM: div_nxt = DIV_W'({cfg.mult, 2'b0}) + DIV_W'({cfg.mult, 1'b0});
    endcase
    s0_pipe_nxt.rem        = '0;
    s0_pipe_nxt.work       = in_bit_index[IDX_W-1:LOW_W];
    s0_pipe_nxt.low        = in_bit_index[LOW_W-1:0];
    s0_pipe_nxt.idx        = in_bit_index;
    s0_pipe_nxt.div        = div_nxt;
    s0_pipe_nxt.modulation = in_modulation;
    s0_pipe_nxt.data_bit   = in_data_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      s0_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_pipe_r <= s0_pipe_nxt;
  end

  assign div_vld[0]  = s0_vld_r;
  assign div_pipe[0] = s0_pipe_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ofdmbi_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (div_vld[g]),
      .in_pipe  (div_pipe[g]),
      .out_vld  (div_vld[g+1]),
      .out_pipe (div_pipe[g+1])
    );
  end

  ofdmbi_perm u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (div_vld[DIV_STAGES]),
    .in_pipe (div_pipe[DIV_STAGES]),
    .out_vld (out_valid),
    .out_res (res)
  );

  assign out_symbol_number     = res.symbol_number;
  assign out_permuted_position = res.permuted_position;
  assign out_dest_index        = res.dest_index;
  assign out_subcarrier        = res.subcarrier;
  assign out_bit_out           = res.bit_out;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("request did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##7 !out_valid)
    else $error("result without request");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[DIV_STAGES] |-> (div_pipe[DIV_STAGES].rem < div_pipe[DIV_STAGES].div))
    else $error("divider remainder out of range");

  a_dest_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dest_index >= DEST_W'(out_permuted_position)))
    else $error("destination below permuted position");

endmodule

`default_nettype wire

// ----- test/ofdmbi_addr_checker.sv -----
`timescale 1ns / 1ps

module ofdmbi_addr_checker
  import ofdmbi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [IDX_W-1:0]      in_bit_index,
  input  logic [1:0]            in_modulation,
  input  logic                  in_data_bit,
  input  logic                  out_valid,
  input  logic [SYM_W-1:0]      out_symbol_number,
  input  logic [POS_W-1:0]      out_permuted_position,
  input  logic [DEST_W-1:0]     out_dest_index,
  input  logic [SC_W-1:0]       out_subcarrier,
  input  logic                  out_bit_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    mismatches,
  output int                    pending
);

  logic [SUBC_W-1:0] subc_setting;
  res_t              expected_addrs[$];
  res_t              want;

  function automatic res_t interleave_address(input logic [IDX_W-1:0] idx,
                                              input logic [1:0] modulation,
                                              input logic data_bit,
                                              input logic [SUBC_W-1:0] subc);
    int unsigned nsub, bps, ncbps, nrow, step, sym, k, p1, shift, p2;
    res_t r;
    nsub = subc;
    if (nsub < COLUMNS) nsub = COLUMNS;
    if (nsub > MAX_SUBCARRIERS) nsub = MAX_SUBCARRIERS;
    nsub = nsub - nsub % COLUMNS;
    case (modulation)
      MOD_BPSK:  bps = 1;
      MOD_QPSK:  bps = 2;
      MOD_16QAM: bps = 4;
      default:   bps = 6;
    endcase
    ncbps = nsub * bps;
    nrow  = ncbps / COLUMNS;
    step  = (bps / 2 == 0) ? 1 : bps / 2;
    sym   = idx / ncbps;
    k     = idx % ncbps;
    p1    = nrow * (k % COLUMNS) + k / COLUMNS;
    shift = (COLUMNS * p1) / ncbps;
    p2    = step * (p1 / step) + ((p1 + ncbps - shift) % step);
    r.symbol_number     = SYM_W'(sym);
    r.permuted_position = POS_W'(p2);
    r.dest_index        = DEST_W'(sym * ncbps + p2);
    r.subcarrier        = SC_W'(p2 / bps);
    r.bit_out           = data_bit;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      subc_setting = SUBC_RESET;
      expected_addrs.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_NUM_SUBC)
        subc_setting = pwdata[SUBC_W-1:0];
      if (out_valid) begin
        if (expected_addrs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual dest %0d pos %0d",
                   $time, out_dest_index, out_permuted_position);
        end else begin
          want = expected_addrs.pop_front();
          check_field("symbol_number", want.symbol_number, out_symbol_number);
          check_field("permuted_position", want.permuted_position, out_permuted_position);
          check_field("dest_index", want.dest_index, out_dest_index);
          check_field("subcarrier", want.subcarrier, out_subcarrier);
          check_field("bit_out", want.bit_out, out_bit_out);
        end
      end
      if (start && !busy)
        expected_addrs.insert(expected_addrs.size(),
                              interleave_address(in_bit_index, in_modulation,
                                                 in_data_bit, subc_setting));
    end
    pending = expected_addrs.size();
  end

endmodule

// ----- test/ofdm_bit_interleave_address_tb.sv -----
`timescale 1ns / 1ps

module ofdm_bit_interleave_address_tb;
  import ofdmbi_pkg::*;

  localparam int REG_SPARE       = 1;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 11;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IDX_W-1:0]      in_bit_index = '0;
  logic [1:0]            in_modulation = MOD_BPSK;
  logic                  in_data_bit = 1'b0;
  logic                  out_valid;
  logic [SYM_W-1:0]      out_symbol_number;
  logic [POS_W-1:0]      out_permuted_position;
  logic [DEST_W-1:0]     out_dest_index;
  logic [SC_W-1:0]       out_subcarrier;
  logic                  out_bit_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int                    mismatches;
  int                    pending;
  int unsigned           cycles = 0;

  int unsigned phase_subc[NUM_PHASES] = '{16, 256, 0, 511, 257, 100, 17, 255, 48, 48, 240};
  int          phase_reg[NUM_PHASES]  = '{REG_NUM_SUBC, REG_NUM_SUBC, REG_NUM_SUBC,
                                          REG_NUM_SUBC, REG_NUM_SUBC, REG_NUM_SUBC,
                                          REG_NUM_SUBC, REG_NUM_SUBC, REG_SPARE,
                                          REG_NUM_SUBC, REG_NUM_SUBC};

  always #10 clk = ~clk;

  ofdm_bit_interleave_address uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_bit_index(in_bit_index), .in_modulation(in_modulation), .in_data_bit(in_data_bit),
    .out_valid(out_valid), .out_symbol_number(out_symbol_number),
    .out_permuted_position(out_permuted_position), .out_dest_index(out_dest_index),
    .out_subcarrier(out_subcarrier), .out_bit_out(out_bit_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  ofdmbi_addr_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_bit_index(in_bit_index), .in_modulation(in_modulation), .in_data_bit(in_data_bit),
    .out_valid(out_valid), .out_symbol_number(out_symbol_number),
    .out_permuted_position(out_permuted_position), .out_dest_index(out_dest_index),
    .out_subcarrier(out_subcarrier), .out_bit_out(out_bit_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input int index, input int unsigned value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = CFG_ADDR_W'(index * 4);
    pwdata  = ($urandom() & ~32'h1ff) | (value & 32'h1ff);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_request(input int unsigned idx, input logic [1:0] modulation,
                              input logic bit_value, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         = 1'b1;
    in_bit_index  = IDX_W'(idx);
    in_modulation = modulation;
    in_data_bit   = bit_value;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 65535);
    if (r < 9) return $urandom_range(0, 3071);
    return $urandom_range(60000, 65535);
  endfunction

  task automatic random_burst(input bit no_gaps_first);
    for (int n = 0; n < ITEMS_PER_PHASE; n++)
      send_request(pick_index(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   (no_gaps_first && n < 20) ? 0 : pick_gap());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int m = 0; m < 4; m++) begin
      send_request(0, 2'(m), 1'b0, 0);
      send_request(65535, 2'(m), 1'b1, 0);
    end
    send_request(79, MOD_BPSK, 1'b1, 0);
    send_request(80, MOD_BPSK, 1'b0, 1);
    send_request(159, MOD_QPSK, 1'b1, 0);
    send_request(160, MOD_QPSK, 1'b0, 2);
    send_request(319, MOD_16QAM, 1'b1, 0);
    send_request(320, MOD_16QAM, 1'b0, 0);
    send_request(479, MOD_64QAM, 1'b1, 0);
    send_request(480, MOD_64QAM, 1'b0, 0);
    random_burst(1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(phase_reg[p], phase_subc[p]);
      if (phase_subc[p] == 16) begin
        send_request(15, MOD_BPSK, 1'b1, 0);
        send_request(16, MOD_BPSK, 1'b0, 0);
      end else if (phase_subc[p] == 256) begin
        send_request(1535, MOD_64QAM, 1'b1, 0);
        send_request(1536, MOD_64QAM, 1'b0, 0);
      end
      random_burst(p % 2 == 0);
      drain();
    end

    repeat (PIPE_LAT + 5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
